// File: sv/assert_macros.svh
// Shared assertion forms; the using scope supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pulse train sequencer check failed");

// next-cycle implication
`define PTS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pulse train sequencer check failed");

`endif

// File: sv/pts_pkg.sv
package pts_pkg;

	localparam int CLK_W       = 40;
	localparam int CODE_W      = 16;
	localparam int TICKS_W     = 32;
	localparam int IDX_W       = 3;
	localparam int COUNT_W     = 32;
	localparam int PADDR_W     = 5;
	localparam int MAX_RESULTS = 10;
	localparam int EVENT_CAP   = 64;
	localparam int RES_CNT_W   = 4;
	localparam int ITER_W      = 7;

	localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};
	localparam logic [1:0]       MODE_GND  = 2'b11;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_START = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		EV_LATCH      = 3'd0,
		EV_DONE       = 3'd1,
		EV_START_OK   = 3'd2,
		EV_START_BUSY = 3'd3,
		EV_STOPPED    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		REG_MODE_CH0  = 3'd0,
		REG_MODE_CH1  = 3'd1,
		REG_STAGES    = 3'd2,
		REG_PERIOD    = 3'd3,
		REG_TRAIN     = 3'd4,
		REG_PARK_CH0  = 3'd5,
		REG_PARK_CH1  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		op_t                      op;
		logic [IDX_W-1:0]         index;
		logic signed [CODE_W-1:0] code_ch0;
		logic signed [CODE_W-1:0] code_ch1;
		logic [TICKS_W-1:0]       ticks;
	} cmd_t;

	typedef struct packed {
		logic [1:0]               mode_ch0;
		logic [1:0]               mode_ch1;
		logic [3:0]               stages_in_use;
		logic [TICKS_W-1:0]       period_ticks;
		logic [TICKS_W-1:0]       train_ticks;
		logic signed [CODE_W-1:0] park_ch0;
		logic signed [CODE_W-1:0] park_ch1;
	} cfg_t;

	typedef struct packed {
		kind_t                    kind;
		logic [1:0]               latch_mask;
		logic signed [CODE_W-1:0] dac_ch0;
		logic signed [CODE_W-1:0] dac_ch1;
		logic [1:0]               out_mode_ch0;
		logic [1:0]               out_mode_ch1;
		logic [COUNT_W-1:0]       pulses_done;
		logic                     last;
	} result_t;

endpackage

// File: sv/pts_if.sv
interface pts_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [2:0]         stage_index;
	logic signed [15:0] stage_code_ch0;
	logic signed [15:0] stage_code_ch1;
	logic [31:0]        stage_ticks;

	modport source (output valid, operation, stage_index, stage_code_ch0, stage_code_ch1,
		stage_ticks, input ready);
	modport sink (input valid, operation, stage_index, stage_code_ch0, stage_code_ch1,
		stage_ticks, output ready);
endinterface

interface pts_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         event_kind;
	logic [1:0]         latch_mask;
	logic signed [15:0] dac_ch0;
	logic signed [15:0] dac_ch1;
	logic [1:0]         out_mode_ch0;
	logic [1:0]         out_mode_ch1;
	logic [31:0]        pulses_done;
	logic               last;

	modport source (output valid, event_kind, latch_mask, dac_ch0, dac_ch1, out_mode_ch0,
		out_mode_ch1, pulses_done, last, input ready);
	modport sink (input valid, event_kind, latch_mask, dac_ch0, dac_ch1, out_mode_ch0,
		out_mode_ch1, pulses_done, last, output ready);
endinterface

// File: sv/pulse_train_sequencer.sv
// channel   direction  handshake          word
// item      in         valid/ready        operation, stage index, codes, stage ticks
// result    out        valid/ready        event kind, mask, codes, modes, pulse count, last
// config    in         APB write/read     seven registers at byte address 4*i
//
// A tick passes each due event through the end and due compare in the test state and
// then the shared 40-bit offset adder in the exec state, either of which can stall on
// the output; a start or stop then passes through the flush state, a stage write does not.
// Reset clears all control state at once; the stage store is not cleared.
// A two-word queue lets the input keep flowing while the sequencer stalls on the output, until the queue is full.
module pulse_train_sequencer import pts_pkg::*; #(
	parameter int MAX_STAGES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	pts_item_if.sink           item,
	pts_result_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t cfg;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	pts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pts_front #(.MAX_STAGES(MAX_STAGES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	pts_back #(.MAX_STAGES(MAX_STAGES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg),
		.result    (result)
	);

endmodule

// File: sv/pts_regs.sv
module pts_regs import pts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	assign sel    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_ch0      <= MODE_GND;
			cfg_q.mode_ch1      <= MODE_GND;
			cfg_q.stages_in_use <= '0;
			cfg_q.period_ticks  <= TICKS_W'(1);
			cfg_q.train_ticks   <= '0;
			cfg_q.park_ch0      <= '0;
			cfg_q.park_ch1      <= '0;
		end else if (wr_en) begin
			case (sel)
				REG_MODE_CH0: cfg_q.mode_ch0      <= pwdata[1:0];
				REG_MODE_CH1: cfg_q.mode_ch1      <= pwdata[1:0];
				REG_STAGES:   cfg_q.stages_in_use <= pwdata[3:0];
				REG_PERIOD:   cfg_q.period_ticks  <= pwdata;
				REG_TRAIN:    cfg_q.train_ticks   <= pwdata;
				REG_PARK_CH0: cfg_q.park_ch0      <= pwdata[CODE_W-1:0];
				REG_PARK_CH1: cfg_q.park_ch1      <= pwdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_MODE_CH0: prdata = {30'b0, cfg_q.mode_ch0};
			REG_MODE_CH1: prdata = {30'b0, cfg_q.mode_ch1};
			REG_STAGES:   prdata = {28'b0, cfg_q.stages_in_use};
			REG_PERIOD:   prdata = cfg_q.period_ticks;
			REG_TRAIN:    prdata = cfg_q.train_ticks;
			REG_PARK_CH0: prdata = {16'b0, cfg_q.park_ch0};
			REG_PARK_CH1: prdata = {16'b0, cfg_q.park_ch1};
			default:      prdata = '0;
		endcase
	end

endmodule

// File: sv/pts_front.sv
module pts_front import pts_pkg::*; #(
	parameter int MAX_STAGES = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	pts_item_if.sink item,
	output cmd_t    cmd,
	output logic    cmd_valid,
	input  logic    cmd_pop
);

	cmd_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       accept;
	logic       keep;
	logic       push;
	cmd_t       decoded;

	assign item.ready = (count_q != 2'd2);
	assign accept     = item.valid && item.ready;

	always_comb begin
		decoded.op       = op_t'(item.operation);
		decoded.index    = item.stage_index;
		decoded.code_ch0 = item.stage_code_ch0;
		decoded.code_ch1 = item.stage_code_ch1;
		decoded.ticks    = item.stage_ticks;
	end

	// drop stage writes that fall outside the store
	assign keep = !((decoded.op == OP_WRITE) && (int'(item.stage_index) >= MAX_STAGES));
	assign push = accept && keep;

	assign cmd       = q_q[rd_ptr_q];
	assign cmd_valid = (count_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/pts_back.sv
module pts_back import pts_pkg::*; #(
	parameter int MAX_STAGES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	input  cfg_t        cfg,
	pts_result_if.source result
);

	localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int EW = $clog2(MAX_STAGES + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_TEST  = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	function automatic logic [3:0] grounded(input logic [3:0] m, input logic [1:0] d);
		logic [3:0] r;
		r = m;
		if (d[0]) r[1:0] = MODE_GND;
		if (d[1]) r[3:2] = MODE_GND;
		return r;
	endfunction

	// stage store, undefined until written
	logic [CODE_W-1:0]  code_a_q [MAX_STAGES];
	logic [CODE_W-1:0]  code_b_q [MAX_STAGES];
	logic [TICKS_W-1:0] len_q    [MAX_STAGES];

	state_t             state_q;
	logic               running_q;
	logic [EW-1:0]      event_q;
	logic [CLK_W-1:0]   clock_q;
	logic [CLK_W-1:0]   origin_q;
	logic [CLK_W-1:0]   due_q;
	logic [COUNT_W-1:0] pulses_q;
	logic [1:0]         drive_q;
	logic [3:0]         mode_q;
	logic [RES_CNT_W-1:0] res_cnt_q;
	logic [ITER_W-1:0]  iter_q;

	logic               hold_valid_q;
	result_t            hold_q;
	logic               out_valid_q;
	result_t            out_q;

	logic [EW-1:0]      ns;
	logic [EW-1:0]      e;
	logic               is_stage;
	logic [IW-1:0]      rd_idx;
	logic [5:0]         idx_ext;
	logic [IW-1:0]      waddr;
	logic               store_we;
	logic [CODE_W-1:0]  c0;
	logic [CODE_W-1:0]  c1;
	logic [3:0]         mode_exec;
	logic [3:0]         stop_modes;
	logic [3:0]         end_modes;
	logic [TICKS_W-1:0] period_eff;
	logic [CLK_W-1:0]   add_a;
	logic [CLK_W-1:0]   add_b;
	logic [CLK_W-1:0]   sum;
	logic [CLK_W-1:0]   clock_inc;
	logic               cap;
	logic               end_hit;
	logic               not_due;
	logic [1:0]         start_mask;
	logic [1:0]         stop_mask;
	logic               out_free;
	logic               emit_ok;
	logic               emit_want;
	logic               go;
	logic               emit_fire;
	logic               flush_fire;
	result_t            new_res;

	// event decode
	always_comb begin
		if (drive_q == 2'b00) begin
			ns = '0;
		end else if (int'(cfg.stages_in_use) > MAX_STAGES) begin
			ns = EW'(MAX_STAGES);
		end else begin
			ns = EW'(cfg.stages_in_use);
		end
	end

	assign e        = (event_q > ns) ? ns : event_q;
	assign is_stage = (e < ns);
	assign rd_idx   = e[IW-1:0];
	assign c0       = is_stage ? code_a_q[rd_idx] : cfg.park_ch0;
	assign c1       = is_stage ? code_b_q[rd_idx] : cfg.park_ch1;

	assign end_modes = grounded(mode_q, drive_q);

	always_comb begin
		mode_exec = mode_q;
		if (drive_q != 2'b00) begin
			if (e == '0) begin
				if (drive_q[0]) mode_exec[1:0] = {1'b0, cfg.mode_ch0[0]};
				if (drive_q[1]) mode_exec[3:2] = {1'b0, cfg.mode_ch1[0]};
			end else if (e == ns) begin
				mode_exec = end_modes;
			end
		end
	end

	// one adder: next stage offset or next pulse origin
	assign period_eff = (cfg.period_ticks == '0) ? TICKS_W'(1) : cfg.period_ticks;
	assign add_a      = is_stage ? due_q : origin_q;
	assign add_b      = is_stage ? CLK_W'(len_q[rd_idx]) : CLK_W'(period_eff);
	assign sum        = add_a + add_b;

	assign clock_inc = (clock_q != CLOCK_MAX) ? clock_q + CLK_W'(1) : clock_q;
	assign cap       = (res_cnt_q == RES_CNT_W'(MAX_RESULTS)) || (iter_q == ITER_W'(EVENT_CAP));
	assign end_hit   = (origin_q >= CLK_W'(cfg.train_ticks));
	assign not_due   = (due_q > clock_q);

	assign start_mask = (cfg.stages_in_use == '0) ? 2'b00 :
		{~cfg.mode_ch1[1], ~cfg.mode_ch0[1]};
	assign stop_mask  = (running_q && drive_q != 2'b00) ? drive_q : 2'b00;
	assign stop_modes = grounded(mode_q, stop_mask);

	always_comb begin
		emit_want = 1'b0;
		new_res   = '0;
		new_res.out_mode_ch0 = mode_q[1:0];
		new_res.out_mode_ch1 = mode_q[3:2];
		new_res.pulses_done  = pulses_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_START: begin
							emit_want = 1'b1;
							if (running_q) begin
								new_res.kind = EV_START_BUSY;
							end else begin
								new_res.kind        = EV_START_OK;
								new_res.pulses_done = '0;
							end
						end
						OP_STOP: begin
							emit_want            = 1'b1;
							new_res.kind         = EV_STOPPED;
							new_res.latch_mask   = stop_mask;
							new_res.dac_ch0      = stop_mask[0] ? cfg.park_ch0 : '0;
							new_res.dac_ch1      = stop_mask[1] ? cfg.park_ch1 : '0;
							new_res.out_mode_ch0 = stop_modes[1:0];
							new_res.out_mode_ch1 = stop_modes[3:2];
						end
						default: ;
					endcase
				end
			end
			ST_TEST: begin
				if (!cap && end_hit) begin
					emit_want            = 1'b1;
					new_res.kind         = EV_DONE;
					new_res.out_mode_ch0 = end_modes[1:0];
					new_res.out_mode_ch1 = end_modes[3:2];
				end
			end
			ST_EXEC: begin
				if (drive_q != 2'b00) begin
					emit_want            = 1'b1;
					new_res.kind         = EV_LATCH;
					new_res.latch_mask   = drive_q;
					new_res.dac_ch0      = drive_q[0] ? c0 : '0;
					new_res.dac_ch1      = drive_q[1] ? c1 : '0;
					new_res.out_mode_ch0 = mode_exec[1:0];
					new_res.out_mode_ch1 = mode_exec[3:2];
					new_res.pulses_done  = is_stage ? pulses_q : pulses_q + COUNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	// a result waits in the hold slot until the next one, or the flush, shows whether it is last
	assign out_free   = !out_valid_q || result.ready;
	assign emit_ok    = !hold_valid_q || out_free;
	assign go         = !emit_want || emit_ok;
	assign emit_fire  = emit_want && emit_ok;
	assign flush_fire = (state_q == ST_FLUSH) && hold_valid_q && out_free;
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid && go;

	assign idx_ext  = {3'b000, cmd.index};
	assign waddr    = idx_ext[IW-1:0];
	assign store_we = cmd_pop && (cmd.op == OP_WRITE);

	always_ff @(posedge clk) begin
		if (store_we) begin
			code_a_q[waddr] <= cmd.code_ch0;
			code_b_q[waddr] <= cmd.code_ch1;
			len_q[waddr]    <= cmd.ticks;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			hold_q <= new_res;
		end
		if ((emit_fire && hold_valid_q) || flush_fire) begin
			out_q <= result_t'({hold_q[$bits(result_t)-1:1], flush_fire});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_fire) begin
				hold_valid_q <= 1'b1;
			end else if (flush_fire) begin
				hold_valid_q <= 1'b0;
			end
			if ((emit_fire && hold_valid_q) || flush_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			running_q <= 1'b0;
			event_q   <= '0;
			clock_q   <= '0;
			origin_q  <= '0;
			due_q     <= '0;
			pulses_q  <= '0;
			drive_q   <= 2'b00;
			mode_q    <= {MODE_GND, MODE_GND};
			res_cnt_q <= '0;
			iter_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.op)
							OP_TICK: begin
								if (running_q) begin
									res_cnt_q <= '0;
									iter_q    <= '0;
									state_q   <= ST_TEST;
								end
							end
							OP_START: begin
								if (!running_q) begin
									drive_q   <= start_mask;
									running_q <= 1'b1;
									event_q   <= '0;
									clock_q   <= '0;
									origin_q  <= '0;
									due_q     <= '0;
									pulses_q  <= '0;
								end
								state_q <= ST_FLUSH;
							end
							OP_STOP: begin
								mode_q    <= stop_modes;
								running_q <= 1'b0;
								state_q   <= ST_FLUSH;
							end
							default: ;
						endcase
					end
				end
				ST_TEST: begin
					if (cap) begin
						clock_q <= clock_inc;
						state_q <= ST_FLUSH;
					end else if (go) begin
						iter_q <= iter_q + ITER_W'(1);
						if (end_hit) begin
							mode_q    <= end_modes;
							running_q <= 1'b0;
							state_q   <= ST_FLUSH;
						end else if (not_due) begin
							clock_q <= clock_inc;
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (go) begin
						mode_q <= mode_exec;
						if (is_stage) begin
							event_q <= e + EW'(1);
							due_q   <= sum;
						end else begin
							pulses_q <= pulses_q + COUNT_W'(1);
							event_q  <= '0;
							origin_q <= sum;
							due_q    <= sum;
						end
						if (drive_q != 2'b00) begin
							res_cnt_q <= res_cnt_q + RES_CNT_W'(1);
						end
						state_q <= ST_TEST;
					end
				end
				ST_FLUSH: begin
					if (!hold_valid_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.event_kind   = out_q.kind;
	assign result.latch_mask   = out_q.latch_mask;
	assign result.dac_ch0      = out_q.dac_ch0;
	assign result.dac_ch1      = out_q.dac_ch1;
	assign result.out_mode_ch0 = out_q.out_mode_ch0;
	assign result.out_mode_ch1 = out_q.out_mode_ch1;
	assign result.pulses_done  = out_q.pulses_done;
	assign result.last         = out_q.last;

endmodule

// File: sv/pts_checker.sv
`include "assert_macros.svh"

module pts_port_checker import pts_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  res_kind,
	input logic [1:0]  res_mask,
	input logic [15:0] res_dac_ch0,
	input logic [15:0] res_dac_ch1,
	input logic [31:0] res_pulses,
	input logic        res_last
);

	logic [69:0] res_word;
	logic        no_mask_kind;
	logic        dac_clean;

	assign res_word     = {res_kind, res_mask, res_dac_ch0, res_dac_ch1, res_pulses, res_last};
	assign no_mask_kind = (res_kind == EV_DONE) || (res_kind == EV_START_OK) ||
		(res_kind == EV_START_BUSY);
	assign dac_clean    = (res_mask[0] || res_dac_ch0 == 16'd0) &&
		(res_mask[1] || res_dac_ch1 == 16'd0);

	// a stalled word holds
	`PTS_ASSERT_NXT(a_hold, res_valid && !res_ready, res_valid && $stable(res_word))

	// only latch and stop words carry a mask
	`PTS_ASSERT_IMP(a_mask, res_valid && no_mask_kind, res_mask == 2'b00)

	// a channel not latched reads zero
	`PTS_ASSERT_IMP(a_dac, res_valid, dac_clean)

	// everything but a latch closes its item
	`PTS_ASSERT_IMP(a_last, res_valid && res_kind != EV_LATCH, res_last)

endmodule

bind pulse_train_sequencer pts_port_checker u_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_kind    (result.event_kind),
	.res_mask    (result.latch_mask),
	.res_dac_ch0 (result.dac_ch0),
	.res_dac_ch1 (result.dac_ch1),
	.res_pulses  (result.pulses_done),
	.res_last    (result.last)
);

// File: verif/pts_checker.sv
`timescale 1ns / 100ps

module pts_checker import pts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	pts_item_if                item,
	pts_result_if              result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output int                 errors,
	output int                 pending,
	output logic               playing
);

	localparam int          N_STAGES  = 8;
	localparam logic [63:0] CLOCK_TOP = 64'(CLOCK_MAX);

	logic [CODE_W-1:0]  stage_code_ch0 [N_STAGES];
	logic [CODE_W-1:0]  stage_code_ch1 [N_STAGES];
	logic [TICKS_W-1:0] stage_len [N_STAGES];

	cfg_t               regs;
	logic               train_on;
	int                 stage_pos;
	logic [63:0]        train_time;
	logic [63:0]        pulse_start;
	logic [63:0]        event_offset;
	logic [COUNT_W-1:0] pulse_count;
	logic [1:0]         drive;
	logic [3:0]         mode_now;

	result_t            queued_events [$];
	int                 words_this_item;

	task automatic emit(kind_t k, logic [1:0] mask, logic [CODE_W-1:0] c0,
		logic [CODE_W-1:0] c1);
		result_t w;
		w.kind         = k;
		w.latch_mask   = mask;
		w.dac_ch0      = mask[0] ? c0 : '0;
		w.dac_ch1      = mask[1] ? c1 : '0;
		w.out_mode_ch0 = mode_now[1:0];
		w.out_mode_ch1 = mode_now[3:2];
		w.pulses_done  = pulse_count;
		w.last         = 1'b0;
		queued_events.push_back(w);
		words_this_item++;
	endtask

	task automatic ground_driven();
		if (drive[0]) mode_now[1:0] = MODE_GND;
		if (drive[1]) mode_now[3:2] = MODE_GND;
	endtask

	// Work through every due event of one tick, within the per-tick caps.
	task automatic play_tick();
		int                n;
		int                iter;
		int                ns;
		int                e;
		logic [CODE_W-1:0] c0;
		logic [CODE_W-1:0] c1;
		n    = 0;
		iter = 0;
		while (n < MAX_RESULTS && iter < EVENT_CAP) begin
			iter++;
			// end test first, so done follows the completing off event at once
			if (pulse_start >= 64'(regs.train_ticks)) begin
				ground_driven();
				train_on = 1'b0;
				emit(EV_DONE, 2'b00, '0, '0);
				return;
			end
			if (pulse_start + event_offset > train_time) break;
			if (drive == 2'b00)
				ns = 0;
			else
				ns = (regs.stages_in_use > N_STAGES) ? N_STAGES : int'(regs.stages_in_use);
			e = (stage_pos > ns) ? ns : stage_pos;
			if (e < ns) begin
				c0 = stage_code_ch0[e];
				c1 = stage_code_ch1[e];
			end else begin
				c0 = regs.park_ch0;
				c1 = regs.park_ch1;
			end
			if (drive != 2'b00) begin
				if (e == 0) begin
					if (drive[0]) mode_now[1:0] = {1'b0, regs.mode_ch0[0]};
					if (drive[1]) mode_now[3:2] = {1'b0, regs.mode_ch1[0]};
				end else if (e == ns) begin
					ground_driven();
				end
			end
			if (e < ns) begin
				stage_pos    = e + 1;
				event_offset = event_offset + 64'(stage_len[e]);
			end else begin
				pulse_count++;
				stage_pos    = 0;
				event_offset = '0;
				pulse_start  = pulse_start +
					((regs.period_ticks == 0) ? 64'd1 : 64'(regs.period_ticks));
			end
			if (drive != 2'b00) begin
				emit(EV_LATCH, drive, c0, c1);
				n++;
			end
		end
		if (train_time < CLOCK_TOP) train_time++;
	endtask

	task automatic take_command();
		result_t    w;
		logic [1:0] m;
		words_this_item = 0;
		case (op_t'(item.operation))
			OP_TICK: begin
				if (train_on) play_tick();
			end
			OP_WRITE: begin
				stage_code_ch0[item.stage_index] = item.stage_code_ch0;
				stage_code_ch1[item.stage_index] = item.stage_code_ch1;
				stage_len[item.stage_index]      = item.stage_ticks;
			end
			OP_START: begin
				if (train_on) begin
					emit(EV_START_BUSY, 2'b00, '0, '0);
				end else begin
					m = {regs.mode_ch1 <= 2'd1, regs.mode_ch0 <= 2'd1};
					if (regs.stages_in_use == 0) m = 2'b00;
					drive        = m;
					train_on     = 1'b1;
					stage_pos    = 0;
					train_time   = '0;
					pulse_start  = '0;
					event_offset = '0;
					pulse_count  = '0;
					emit(EV_START_OK, 2'b00, '0, '0);
				end
			end
			OP_STOP: begin
				m = 2'b00;
				if (train_on && drive != 2'b00) begin
					m = drive;
					ground_driven();
				end
				train_on = 1'b0;
				emit(EV_STOPPED, m, regs.park_ch0, regs.park_ch1);
			end
			default: ;
		endcase
		// mark the final word of this command
		if (words_this_item > 0) begin
			w = queued_events[$];
			queued_events.pop_back();
			w.last = 1'b1;
			queued_events.push_back(w);
		end
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endfunction

	task automatic compare_word(result_t want);
		check_field("event_kind", 32'(want.kind), 32'(result.event_kind));
		check_field("latch_mask", 32'(want.latch_mask), 32'(result.latch_mask));
		check_field("dac_ch0", 32'(want.dac_ch0), 32'(result.dac_ch0));
		check_field("dac_ch1", 32'(want.dac_ch1), 32'(result.dac_ch1));
		check_field("out_mode_ch0", 32'(want.out_mode_ch0), 32'(result.out_mode_ch0));
		check_field("out_mode_ch1", 32'(want.out_mode_ch1), 32'(result.out_mode_ch1));
		check_field("pulses_done", want.pulses_done, result.pulses_done);
		check_field("last", 32'(want.last), 32'(result.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.mode_ch0      = MODE_GND;
			regs.mode_ch1      = MODE_GND;
			regs.stages_in_use = '0;
			regs.period_ticks  = 32'd1;
			regs.train_ticks   = '0;
			regs.park_ch0      = '0;
			regs.park_ch1      = '0;
			train_on           = 1'b0;
			stage_pos          = 0;
			train_time         = '0;
			pulse_start        = '0;
			event_offset       = '0;
			pulse_count        = '0;
			drive              = 2'b00;
			mode_now           = 4'hF;
			queued_events.delete();
			errors             = 0;
			pending            = 0;
			playing            = 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (queued_events.size() == 0) begin
					errors++;
					$display("%0t: result word of kind %0d with nothing predicted",
						$time, result.event_kind);
				end else begin
					compare_word(queued_events.pop_front());
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_MODE_CH0: regs.mode_ch0      = pwdata[1:0];
					REG_MODE_CH1: regs.mode_ch1      = pwdata[1:0];
					REG_STAGES:   regs.stages_in_use = pwdata[3:0];
					REG_PERIOD:   regs.period_ticks  = pwdata;
					REG_TRAIN:    regs.train_ticks   = pwdata;
					REG_PARK_CH0: regs.park_ch0      = pwdata[15:0];
					REG_PARK_CH1: regs.park_ch1      = pwdata[15:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready) take_command();
			pending = queued_events.size();
			playing = train_on;
		end
	end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import pts_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYC  = 300;
	localparam int HOLD_CYC    = 400;
	localparam int TARGET      = 130;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int                 errors;
	int                 pending;
	logic               playing;
	bit                 quiet;
	bit                 hold_req;
	int                 counted_items;
	int                 idle_cycles;

	pts_item_if   item_ch ();
	pts_result_if result_ch ();

	pulse_train_sequencer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pts_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.errors  (errors),
		.pending (pending),
		.playing (playing)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Offer one command word; return at the edge that takes it.
	task automatic send(op_t op, logic [2:0] idx, logic [15:0] c0, logic [15:0] c1,
		logic [31:0] ticks);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (op != OP_TICK || playing) counted_items++;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.operation      <= op;
		item_ch.stage_index    <= idx;
		item_ch.stage_code_ch0 <= c0;
		item_ch.stage_code_ch1 <= c1;
		item_ch.stage_ticks    <= ticks;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic send_op(op_t op);
		send(op, 3'($urandom), 16'($urandom), 16'($urandom), $urandom);
	endtask

	task automatic write_random_stage();
		send(OP_WRITE, 3'($urandom), 16'($urandom), 16'($urandom),
			($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3));
	endtask

	task automatic apb_write(reg_idx_t r, logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid, drain every predicted word, then let queued commands finish.
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic draw_settings();
		int          r;
		logic [31:0] v;
		apb_write(REG_MODE_CH0, ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1) :
			$urandom_range(2, 3));
		apb_write(REG_MODE_CH1, ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1) :
			$urandom_range(2, 3));
		r = $urandom_range(0, 19);
		v = (r < 15) ? $urandom_range(1, 8) : (r < 17) ? 0 : $urandom_range(9, 15);
		apb_write(REG_STAGES, v);
		r = $urandom_range(0, 19);
		v = (r < 16) ? $urandom_range(1, 12) : (r < 18) ? 0 : $urandom;
		apb_write(REG_PERIOD, v);
		r = $urandom_range(0, 19);
		v = (r < 16) ? $urandom_range(0, 60) : (r < 18) ? 0 : $urandom;
		apb_write(REG_TRAIN, v);
		apb_write(REG_PARK_CH0, {16'b0, 16'($urandom)});
		apb_write(REG_PARK_CH1, {16'b0, 16'($urandom)});
	endtask

	// One train: settings, a few stage rewrites, start, ticks with stray commands.
	task automatic random_phase(bit squeeze);
		int r;
		settle();
		quiet = squeeze ? 1'b0 : ($urandom_range(0, 3) == 0);
		if (squeeze) begin
			// short period against a longer pulse: a backlog of due events
			apb_write(REG_MODE_CH0, 32'd1);
			apb_write(REG_MODE_CH1, 32'd0);
			apb_write(REG_STAGES, 32'd8);
			apb_write(REG_PERIOD, 32'd1);
			apb_write(REG_TRAIN, 32'd6);
		end else begin
			draw_settings();
			repeat ($urandom_range(0, 3)) write_random_stage();
		end
		send_op(OP_START);
		if (squeeze) hold_req = 1'b1;
		repeat ($urandom_range(6, 20)) begin
			r = $urandom_range(0, 11);
			if (r == 0 && !squeeze)
				write_random_stage();
			else if (r == 1)
				send_op(OP_START);
			else if (r == 2 && !squeeze)
				send_op(OP_STOP);
			else
				send_op(OP_TICK);
		end
		if ($urandom_range(0, 1) == 1) send_op(OP_STOP);
	endtask

	// Result side: per-word stall, one long hold-off on request.
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = hold_req ? HOLD_CYC : (quiet ? 0 : $urandom_range(0, 11));
			hold_req = 1'b0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		item_ch.valid          = 1'b0;
		item_ch.operation      = OP_TICK;
		item_ch.stage_index    = '0;
		item_ch.stage_code_ch0 = '0;
		item_ch.stage_code_ch1 = '0;
		item_ch.stage_ticks    = '0;
		quiet                  = 1'b0;
		hold_req               = 1'b0;
		counted_items          = 0;
		idle_cycles            = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every stage entry before any train can read one
		send(OP_WRITE, 3'd0, 16'sh7FFF, 16'sh8000, 32'd1);
		send(OP_WRITE, 3'd1, 16'sh8000, 16'sh7FFF, 32'd0);
		send(OP_WRITE, 3'd2, 16'sh0000, 16'shFFFF, 32'd0);
		send(OP_WRITE, 3'd3, 16'shFFFF, 16'sh0000, 32'd2);
		send(OP_WRITE, 3'd4, 16'sh1234, 16'sh5678, 32'd0);
		send(OP_WRITE, 3'd5, 16'shA5A5, 16'sh5A5A, 32'd1);
		send(OP_WRITE, 3'd6, 16'sh0F0F, 16'shF0F0, 32'd0);
		send(OP_WRITE, 3'd7, 16'sh0001, 16'shFFFE, 32'hFFFF_FFFF);
		// reset settings: nothing driven, zero stages, zero duration
		send_op(OP_TICK);
		send_op(OP_STOP);
		send_op(OP_START);
		send_op(OP_START);
		send_op(OP_TICK);

		// both channels driven, train never ends, stop in mid pulse
		settle();
		apb_write(REG_MODE_CH0, 32'd0);
		apb_write(REG_MODE_CH1, 32'd1);
		apb_write(REG_STAGES, 32'd8);
		apb_write(REG_PERIOD, 32'hFFFF_FFFF);
		apb_write(REG_TRAIN, 32'hFFFF_FFFF);
		apb_write(REG_PARK_CH0, 32'h0000_8000);
		apb_write(REG_PARK_CH1, 32'h0000_7FFF);
		send_op(OP_START);
		repeat (4) send_op(OP_TICK);
		send_op(OP_STOP);

		// oversized stage count, zero period, one channel driven
		settle();
		apb_write(REG_MODE_CH0, 32'd2);
		apb_write(REG_MODE_CH1, 32'd0);
		apb_write(REG_STAGES, 32'd15);
		apb_write(REG_PERIOD, 32'd0);
		apb_write(REG_TRAIN, 32'd3);
		send(OP_WRITE, 3'd7, 16'sh8000, 16'sh7FFF, 32'd0);
		send_op(OP_START);
		repeat (6) send_op(OP_TICK);

		random_phase(1'b1);
		while (counted_items < TARGET) random_phase(1'b0);

		settle();
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
